// ===== rtl/core/mrfb_pkg.sv =====
// Package for the meter readout frame builder: operation and frame kind codes,
// frame byte constants, and the item and burst types.
// Depends on nothing; compile first.
`default_nettype none
package mrfb_pkg;

	localparam int MAX_BURST = 8;

	localparam logic [1:0] OP_BEGIN = 2'd0;
	localparam logic [1:0] OP_FIELD = 2'd1;
	localparam logic [1:0] OP_VALUE = 2'd2;
	localparam logic [1:0] OP_END   = 2'd3;

	localparam logic [1:0] KIND_SIGN_ON  = 2'd0;
	localparam logic [1:0] KIND_OPT_ACK  = 2'd1;
	localparam logic [1:0] KIND_PASSWORD = 2'd2;
	localparam logic [1:0] KIND_DATA_REQ = 2'd3;

	localparam logic [7:0] B_PREAMBLE = 8'h7F;
	localparam logic [7:0] B_SLASH    = 8'h2F;
	localparam logic [7:0] B_QUERY    = 8'h3F;
	localparam logic [7:0] B_BANG     = 8'h21;
	localparam logic [7:0] B_ACK      = 8'h06;
	localparam logic [7:0] B_ZERO     = 8'h30;
	localparam logic [7:0] B_ONE      = 8'h31;
	localparam logic [7:0] B_TWO      = 8'h32;
	localparam logic [7:0] B_CMD_P    = 8'h50;
	localparam logic [7:0] B_CMD_R    = 8'h52;
	localparam logic [7:0] B_CMD_W    = 8'h57;
	localparam logic [7:0] B_LPAREN   = 8'h28;
	localparam logic [7:0] B_RPAREN   = 8'h29;
	localparam logic [7:0] B_SOH      = 8'h01;
	localparam logic [7:0] B_STX      = 8'h02;
	localparam logic [7:0] B_ETX      = 8'h03;
	localparam logic [7:0] B_CR       = 8'h0D;
	localparam logic [7:0] B_LF       = 8'h0A;
	localparam logic [7:0] B_SPACE    = 8'h20;

	typedef struct packed {
		logic [1:0] operation;
		logic [1:0] frame_kind;
		logic       write_request;
		logic       value_wanted;
		logic [7:0] byte_value;
	} item_t;

	// Bytes produced by one item, lane 0 goes out first.
	typedef struct packed {
		logic [MAX_BURST-1:0][7:0] bytes;
		logic [3:0]                count;
		logic                      ends;
	} burst_t;

endpackage
`default_nettype wire

// ===== rtl/core/mrfb_item_if.sv =====
// Input channel of the frame builder: valid/ready plus one item.
// Depends on nothing.
`default_nettype none
interface mrfb_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [1:0] frame_kind;
	logic       write_request;
	logic       value_wanted;
	logic [7:0] byte_value;

	modport source (output valid, operation, frame_kind, write_request, value_wanted,
		byte_value, input ready);
	modport sink (input valid, operation, frame_kind, write_request, value_wanted,
		byte_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mrfb_byte_if.sv =====
// Output channel of the frame builder: valid/ready plus one line byte.
// Depends on nothing.
`default_nettype none
interface mrfb_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_byte;

	modport source (output valid, out_byte, last_byte, input ready);
	modport sink (input valid, out_byte, last_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mrfb_encoder.sv =====
// Frame state and the logic that turns one item into its burst of line bytes.
// Depends on mrfb_pkg.
`default_nettype none
module mrfb_encoder import mrfb_pkg::*; #(
	parameter int PREAMBLE_COUNT = 3
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   load,
	input  wire item_t  item,
	output burst_t      burst
);

	// Preamble length per header length, so a begin never exceeds a full burst.
	localparam int PRE_SHORT = (PREAMBLE_COUNT > MAX_BURST - 2) ? MAX_BURST - 2 : PREAMBLE_COUNT;
	localparam int PRE_DATA  = (PREAMBLE_COUNT > MAX_BURST - 4) ? MAX_BURST - 4 : PREAMBLE_COUNT;
	localparam int PRE_PWD   = (PREAMBLE_COUNT > MAX_BURST - 5) ? MAX_BURST - 5 : PREAMBLE_COUNT;

	logic [1:0] kind_q;
	logic [7:0] bcc_q;
	logic       paren_q;
	logic       val_en_q;
	logic       open_q;

	logic [1:0] kind_d;
	logic [7:0] bcc_d;
	logic       paren_d;
	logic       val_en_d;
	logic       open_d;

	logic [7:0] hdr [MAX_BURST];
	logic [3:0] pre;
	logic [3:0] hlen;
	logic [7:0] cmd;
	logic [2:0] hidx;
	logic [7:0] bcc_end;
	logic       keep;

	always_comb begin
		kind_d   = kind_q;
		bcc_d    = bcc_q;
		paren_d  = paren_q;
		val_en_d = val_en_q;
		open_d   = open_q;
		burst    = '0;
		for (int j = 0; j < MAX_BURST; j++) begin
			hdr[j] = '0;
		end
		pre     = '0;
		hlen    = '0;
		hidx    = '0;
		cmd     = item.write_request ? B_CMD_W : B_CMD_R;
		keep    = item.byte_value != B_SPACE;
		bcc_end = '0;

		unique case (item.operation)
			OP_BEGIN: begin
				kind_d   = item.frame_kind;
				val_en_d = item.write_request | item.value_wanted;
				paren_d  = 1'b0;
				open_d   = 1'b1;
				unique case (item.frame_kind)
					KIND_SIGN_ON: begin
						hdr[0] = B_SLASH;
						hdr[1] = B_QUERY;
						hlen   = 4'd2;
						pre    = 4'(PRE_SHORT);
						bcc_d  = '0;
					end
					KIND_OPT_ACK: begin
						hdr[0] = B_ACK;
						hdr[1] = B_ZERO;
						hlen   = 4'd2;
						pre    = 4'(PRE_SHORT);
						bcc_d  = '0;
					end
					KIND_PASSWORD: begin
						hdr[0] = B_SOH;
						hdr[1] = B_CMD_P;
						hdr[2] = B_ONE;
						hdr[3] = B_STX;
						hdr[4] = B_LPAREN;
						hlen   = 4'd5;
						pre    = 4'(PRE_PWD);
						bcc_d  = B_CMD_P ^ B_ONE ^ B_STX ^ B_LPAREN;
					end
					KIND_DATA_REQ: begin
						hdr[0] = B_SOH;
						hdr[1] = cmd;
						hdr[2] = B_TWO;
						hdr[3] = B_STX;
						hlen   = 4'd4;
						pre    = 4'(PRE_DATA);
						bcc_d  = cmd ^ B_TWO ^ B_STX;
					end
				endcase
				for (int i = 0; i < MAX_BURST; i++) begin
					hidx = 3'(4'(i) - pre);
					if (4'(i) < pre) begin
						burst.bytes[i] = B_PREAMBLE;
					end else if (4'(i) < pre + hlen) begin
						burst.bytes[i] = hdr[hidx];
					end
				end
				burst.count = pre + hlen;
			end
			OP_FIELD: begin
				if (open_q && keep) begin
					burst.bytes[0] = item.byte_value;
					burst.count    = 4'd1;
					if (kind_q[1]) begin
						bcc_d = bcc_q ^ item.byte_value;
					end
				end
			end
			OP_VALUE: begin
				if (open_q && kind_q == KIND_DATA_REQ) begin
					paren_d = 1'b1;
					if (!paren_q) begin
						burst.bytes[0] = B_LPAREN;
						if (val_en_q && keep) begin
							burst.bytes[1] = item.byte_value;
							burst.count    = 4'd2;
							bcc_d          = bcc_q ^ B_LPAREN ^ item.byte_value;
						end else begin
							burst.count = 4'd1;
							bcc_d       = bcc_q ^ B_LPAREN;
						end
					end else if (val_en_q && keep) begin
						burst.bytes[0] = item.byte_value;
						burst.count    = 4'd1;
						bcc_d          = bcc_q ^ item.byte_value;
					end
				end
			end
			OP_END: begin
				if (open_q) begin
					open_d     = 1'b0;
					burst.ends = 1'b1;
					unique case (kind_q)
						KIND_SIGN_ON, KIND_OPT_ACK: begin
							burst.bytes[0] = (kind_q == KIND_SIGN_ON) ? B_BANG : B_ONE;
							burst.bytes[1] = B_CR;
							burst.bytes[2] = B_LF;
							burst.count    = 4'd3;
						end
						KIND_PASSWORD, KIND_DATA_REQ: begin
							if (kind_q == KIND_DATA_REQ && !paren_q) begin
								// No value item came: open the value brackets here.
								bcc_end        = bcc_q ^ B_LPAREN ^ B_RPAREN ^ B_ETX;
								burst.bytes[0] = B_LPAREN;
								burst.bytes[1] = B_RPAREN;
								burst.bytes[2] = B_ETX;
								burst.bytes[3] = bcc_end;
								burst.count    = 4'd4;
								paren_d        = 1'b1;
							end else begin
								bcc_end        = bcc_q ^ B_RPAREN ^ B_ETX;
								burst.bytes[0] = B_RPAREN;
								burst.bytes[1] = B_ETX;
								burst.bytes[2] = bcc_end;
								burst.count    = 4'd3;
							end
							bcc_d = bcc_end;
						end
					endcase
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= '0;
			bcc_q    <= '0;
			paren_q  <= 1'b0;
			val_en_q <= 1'b0;
			open_q   <= 1'b0;
		end else if (load) begin
			kind_q   <= kind_d;
			bcc_q    <= bcc_d;
			paren_q  <= paren_d;
			val_en_q <= val_en_d;
			open_q   <= open_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/meter_readout_frame_builder.sv =====
// Top level of the meter readout frame builder: request register, encoder and
// byte output shifter. Depends on mrfb_pkg, mrfb_item_if, mrfb_byte_if, mrfb_encoder.
//
//   channel | dir | handshake     | payload
//   --------+-----+---------------+------------------------------------------------
//   item    | in  | valid / ready | operation, frame_kind, write_request,
//           |     |               | value_wanted, byte_value
//   frame   | out | valid / ready | out_byte, last_byte
//
// Each request passes through the request register, then its bytes (0 to 8)
// are loaded at once into the output shifter and leave one per cycle while
// frame.ready is high. With the default preamble a begin yields 5 to 8 bytes,
// a field 0 or 1, a value 0 to 2 and an end 0, 3 or 4. A new request is taken
// while the shifter drains its last byte, so single-byte requests stream back
// to back. Reset clears control and frame state only. A stalled output holds
// the shifter; the request register then fills and item.ready drops.
`default_nettype none
module meter_readout_frame_builder import mrfb_pkg::*; #(
	parameter int PREAMBLE_COUNT = 3
) (
	input wire logic     clk,
	input wire logic     arst_n,
	mrfb_item_if.sink    item,
	mrfb_byte_if.source  frame
);

	// Request register
	item_t  item_s1;
	logic   valid_s1;

	// Output shifter: lane 0 is on the line
	logic [MAX_BURST-1:0][7:0] bytes_s2;
	logic [3:0]                cnt_s2;
	logic                      ends_s2;

	burst_t burst;
	logic   pop;
	logic   s2_free;
	logic   advance;
	logic   take;

	assign pop     = frame.valid && frame.ready;
	// Shifter can take a new burst when empty or when its final byte leaves now.
	assign s2_free = (cnt_s2 == 4'd0) || (cnt_s2 == 4'd1 && pop);
	assign advance = valid_s1 && s2_free;
	assign take    = item.valid && item.ready;

	assign item.ready      = !valid_s1 || advance;
	assign frame.valid     = cnt_s2 != 4'd0;
	assign frame.out_byte  = bytes_s2[0];
	assign frame.last_byte = ends_s2 && cnt_s2 == 4'd1;

	// Capture the request; payload needs no reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.operation     <= item.operation;
			item_s1.frame_kind    <= item.frame_kind;
			item_s1.write_request <= item.write_request;
			item_s1.value_wanted  <= item.value_wanted;
			item_s1.byte_value    <= item.byte_value;
		end
	end

	// Build the burst and advance frame state as the request leaves stage 1.
	mrfb_encoder #(
		.PREAMBLE_COUNT(PREAMBLE_COUNT)
	) u_encoder (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (advance),
		.item  (item_s1),
		.burst (burst)
	);

	// Load a fresh burst, or drop the byte just sent and shift the rest down.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2  <= '0;
			ends_s2 <= 1'b0;
		end else if (advance) begin
			cnt_s2  <= burst.count;
			ends_s2 <= burst.ends;
		end else if (pop) begin
			cnt_s2 <= cnt_s2 - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			bytes_s2 <= burst.bytes;
		end else if (pop) begin
			bytes_s2 <= bytes_s2 >> 8;
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_s2 <= 4'(MAX_BURST))
		else $error("output shifter holds more bytes than a burst");

	a_burst_bound: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> burst.count <= 4'(MAX_BURST))
		else $error("encoder produced an oversized burst");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !advance |=> cnt_s2 == $past(cnt_s2) - 4'd1)
		else $error("shifter did not drop the byte just sent");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("pending request lost while output busy");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		frame.valid && frame.last_byte |-> ends_s2 && cnt_s2 == 4'd1)
		else $error("frame end flagged on a byte that is not the final one");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/meter_readout_frame_builder_tb.sv =====
// Self-checking bench for meter_readout_frame_builder: directed table, then random frames.
// Depends on mrfb_pkg, mrfb_item_if, mrfb_byte_if and the frame builder RTL.
`timescale 1ns / 100ps
module meter_readout_frame_builder_tb import mrfb_pkg::*;;

	localparam int PREAMBLE_COUNT = 3;
	localparam int CYCLE_LIMIT    = 200000;
	localparam int RANDOM_TARGET  = 430;
	localparam int IDLE_PERCENT   = 14;
	localparam int DRAIN_LIMIT    = 5000;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} line_byte_t;

	// One row of the directed table. When typed is set, the bytes are written out
	// here, first byte in the top lane; otherwise the frame model supplies them.
	typedef struct {
		item_t       req;
		bit          typed;
		int unsigned count;
		logic [63:0] bytes;
		bit          ends;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	mrfb_item_if item_ch ();
	mrfb_byte_if frame_ch ();

	meter_readout_frame_builder #(
		.PREAMBLE_COUNT(PREAMBLE_COUNT)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_ch),
		.frame (frame_ch)
	);

	// Frame model state, mirrors what the block keeps between requests.
	logic [1:0] cur_kind;
	logic [7:0] frame_bcc;
	logic       paren_sent;
	logic       values_on;
	logic       frame_open;

	line_byte_t burst_q[$];        // bytes the latest request should produce
	line_byte_t pending_bytes[$];  // line bytes still owed by the block
	dir_row_t   dir_rows[$];

	int unsigned mismatches    = 0;
	int unsigned sent_requests = 0;
	int unsigned cycle_count   = 0;
	bit          no_idle       = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d bytes outstanding", cycle_count,
				pending_bytes.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		$display("[%0t] mismatch: %s: got %0h, want %0h", $time, what, got, want);
	endtask

	// Append one byte to the burst; cap the burst at the block's lane count and
	// fold the byte into the block check when it is covered.
	task automatic emit_byte(input logic [7:0] b, input logic last, input bit checked);
		line_byte_t lb;
		if (burst_q.size() < MAX_BURST) begin
			lb.value = b;
			lb.last  = last;
			burst_q.push_back(lb);
			if (checked)
				frame_bcc ^= b;
		end
	endtask

	// Work out the line bytes one request yields and advance the frame state.
	task automatic predict_request(input item_t req);
		logic [7:0] hdr [5];
		int         hlen;
		int         pre;
		burst_q.delete();
		hlen = 0;
		if (req.operation == OP_BEGIN) begin
			// A begin always restarts, abandoning any open frame.
			cur_kind   = req.frame_kind;
			values_on  = req.write_request | req.value_wanted;
			paren_sent = 1'b0;
			frame_bcc  = '0;
			frame_open = 1'b1;
			case (cur_kind)
				KIND_SIGN_ON: begin
					hdr[0] = B_SLASH; hdr[1] = B_QUERY; hlen = 2;
				end
				KIND_OPT_ACK: begin
					hdr[0] = B_ACK; hdr[1] = B_ZERO; hlen = 2;
				end
				KIND_PASSWORD: begin
					hdr[0] = B_SOH; hdr[1] = B_CMD_P; hdr[2] = B_ONE;
					hdr[3] = B_STX; hdr[4] = B_LPAREN; hlen = 5;
				end
				KIND_DATA_REQ: begin
					hdr[0] = B_SOH; hdr[1] = req.write_request ? B_CMD_W : B_CMD_R;
					hdr[2] = B_TWO; hdr[3] = B_STX; hlen = 4;
				end
			endcase
			// Shorten the preamble so the whole begin fits in one burst.
			pre = PREAMBLE_COUNT;
			if (pre > MAX_BURST - hlen)
				pre = MAX_BURST - hlen;
			if (pre < 0)
				pre = 0;
			for (int i = 0; i < pre; i++)
				emit_byte(B_PREAMBLE, 1'b0, 1'b0);
			// SOH itself stays out of the block check.
			for (int i = 0; i < hlen; i++)
				emit_byte(hdr[i], 1'b0, (cur_kind >= KIND_PASSWORD) && (i > 0));
			return;
		end

		// Drop everything else while no frame is open.
		if (!frame_open)
			return;

		case (req.operation)
			OP_FIELD: begin
				if (req.byte_value != B_SPACE)
					emit_byte(req.byte_value, 1'b0, cur_kind >= KIND_PASSWORD);
			end
			OP_VALUE: begin
				// Values belong to data requests only.
				if (cur_kind == KIND_DATA_REQ) begin
					if (!paren_sent) begin
						emit_byte(B_LPAREN, 1'b0, 1'b1);
						paren_sent = 1'b1;
					end
					if (values_on && req.byte_value != B_SPACE)
						emit_byte(req.byte_value, 1'b0, 1'b1);
				end
			end
			OP_END: begin
				if (cur_kind == KIND_SIGN_ON || cur_kind == KIND_OPT_ACK) begin
					emit_byte(cur_kind == KIND_SIGN_ON ? B_BANG : B_ONE, 1'b0, 1'b0);
					emit_byte(B_CR, 1'b0, 1'b0);
					emit_byte(B_LF, 1'b1, 1'b0);
				end else begin
					// A data request with no value still gets its open paren.
					if (cur_kind == KIND_DATA_REQ && !paren_sent) begin
						emit_byte(B_LPAREN, 1'b0, 1'b1);
						paren_sent = 1'b1;
					end
					emit_byte(B_RPAREN, 1'b0, 1'b1);
					emit_byte(B_ETX, 1'b0, 1'b1);
					emit_byte(frame_bcc, 1'b1, 1'b0);
				end
				frame_open = 1'b0;
			end
			default: ;
		endcase
	endtask

	// Present one request at the falling edge, idling now and then, and hold it
	// until the block takes it. Then predict its bytes.
	task automatic issue_request(input item_t req, input bit use_model);
		@(negedge clk);
		while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid         <= 1'b1;
		item_ch.operation     <= req.operation;
		item_ch.frame_kind    <= req.frame_kind;
		item_ch.write_request <= req.write_request;
		item_ch.value_wanted  <= req.value_wanted;
		item_ch.byte_value    <= req.byte_value;
		do
			@(posedge clk);
		while (!item_ch.ready);
		predict_request(req);
		sent_requests++;
		if (use_model)
			foreach (burst_q[i])
				pending_bytes.push_back(burst_q[i]);
	endtask

	task automatic add_row(input logic [1:0] op, input logic [1:0] kind, input logic wr,
		input logic vw, input logic [7:0] b, input bit typed, input int unsigned count,
		input logic [63:0] bytes, input bit ends);
		dir_row_t row;
		row.req.operation     = op;
		row.req.frame_kind    = kind;
		row.req.write_request = wr;
		row.req.value_wanted  = vw;
		row.req.byte_value    = b;
		row.typed             = typed;
		row.count             = count;
		row.bytes             = bytes;
		row.ends              = ends;
		dir_rows.push_back(row);
	endtask

	// Text byte for field and value items: lean on spaces, SOH, ETX and ASCII.
	function automatic logic [7:0] pick_text_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 18)
			return B_SPACE;
		else if (r < 26)
			return B_SOH;
		else if (r < 34)
			return B_ETX;
		else if (r < 64)
			return 8'($urandom_range(8'h30, 8'h5A));
		else
			return 8'($urandom);
	endfunction

	// Mostly well-formed frames with random content; some noise and frames left
	// unterminated so the next begin abandons them.
	task automatic random_frame();
		item_t req;
		int    nf;
		int    nv;
		if ($urandom_range(0, 99) < 10) begin
			req.operation     = 2'($urandom);
			req.frame_kind    = 2'($urandom);
			req.write_request = 1'($urandom);
			req.value_wanted  = 1'($urandom);
			req.byte_value    = 8'($urandom);
			issue_request(req, 1'b1);
			return;
		end
		req.operation     = OP_BEGIN;
		req.frame_kind    = 2'($urandom_range(0, 3));
		req.write_request = 1'($urandom);
		req.value_wanted  = 1'($urandom);
		req.byte_value    = 8'($urandom);
		issue_request(req, 1'b1);
		nf = $urandom_range(0, 6);
		for (int i = 0; i < nf; i++) begin
			req.operation  = OP_FIELD;
			req.byte_value = pick_text_byte();
			issue_request(req, 1'b1);
		end
		nv = (req.frame_kind == KIND_DATA_REQ) ? $urandom_range(0, 4) :
			($urandom_range(0, 99) < 15 ? 1 : 0);
		for (int i = 0; i < nv; i++) begin
			req.operation  = OP_VALUE;
			req.byte_value = pick_text_byte();
			issue_request(req, 1'b1);
		end
		// Now and then slip a field in after the values.
		if (nv != 0 && $urandom_range(0, 99) < 25) begin
			req.operation  = OP_FIELD;
			req.byte_value = pick_text_byte();
			issue_request(req, 1'b1);
		end
		if ($urandom_range(0, 99) < 88) begin
			req.operation  = OP_END;
			req.byte_value = 8'($urandom);
			issue_request(req, 1'b1);
		end
	endtask

	// Sink side: drop ready at random outside the quiet stretch.
	always @(negedge clk)
		frame_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);

	// Compare every byte taken off the line with the oldest one owed.
	always @(posedge clk) begin
		line_byte_t want;
		if (arst_n && frame_ch.valid && frame_ch.ready) begin
			if (pending_bytes.size() == 0) begin
				report_mismatch("byte with none expected", frame_ch.out_byte, 0);
			end else begin
				want = pending_bytes.pop_front();
				if (frame_ch.out_byte !== want.value)
					report_mismatch("out_byte", frame_ch.out_byte, want.value);
				if (frame_ch.last_byte !== want.last)
					report_mismatch("last_byte", frame_ch.last_byte, want.last);
			end
		end
	end

	initial begin
		line_byte_t  lb;
		int unsigned drain;

		arst_n                <= 1'b0;
		item_ch.valid         <= 1'b0;
		item_ch.operation     <= OP_BEGIN;
		item_ch.frame_kind    <= KIND_SIGN_ON;
		item_ch.write_request <= 1'b0;
		item_ch.value_wanted  <= 1'b0;
		item_ch.byte_value    <= '0;
		cur_kind   = KIND_SIGN_ON;
		frame_bcc  = '0;
		paren_sent = 1'b0;
		values_on  = 1'b0;
		frame_open = 1'b0;

		// Directed table. Nothing may leave the line before a frame is open.
		add_row(OP_FIELD, KIND_SIGN_ON, 0, 0, 8'h41, 1, 0, 64'h0, 0);
		add_row(OP_END, KIND_SIGN_ON, 0, 0, 8'h00, 1, 0, 64'h0, 0);
		// Sign-on, begin byte ignored; spaces drop; byte extremes pass.
		add_row(OP_BEGIN, KIND_SIGN_ON, 1, 1, 8'hFF, 1, 5, 64'h7F7F7F2F3F000000, 0);
		add_row(OP_FIELD, KIND_SIGN_ON, 0, 0, B_SPACE, 1, 0, 64'h0, 0);
		add_row(OP_FIELD, KIND_SIGN_ON, 0, 0, 8'h00, 0, 0, 64'h0, 0);
		add_row(OP_FIELD, KIND_SIGN_ON, 0, 0, 8'hFF, 0, 0, 64'h0, 0);
		// Value outside a data request does nothing.
		add_row(OP_VALUE, KIND_SIGN_ON, 0, 0, 8'h35, 1, 0, 64'h0, 0);
		add_row(OP_END, KIND_SIGN_ON, 0, 0, 8'hFF, 1, 3, 64'h210D0A0000000000, 1);
		// Option acknowledge.
		add_row(OP_BEGIN, KIND_OPT_ACK, 0, 0, 8'h00, 1, 5, 64'h7F7F7F0630000000, 0);
		add_row(OP_FIELD, KIND_OPT_ACK, 0, 0, 8'h30, 0, 0, 64'h0, 0);
		add_row(OP_END, KIND_OPT_ACK, 0, 0, 8'h00, 1, 3, 64'h310D0A0000000000, 1);
		// Password: full eight-byte begin; SOH and ETX in the payload stay checked.
		add_row(OP_BEGIN, KIND_PASSWORD, 0, 0, 8'h00, 1, 8, 64'h7F7F7F0150310228, 0);
		add_row(OP_FIELD, KIND_PASSWORD, 0, 0, B_SOH, 0, 0, 64'h0, 0);
		add_row(OP_FIELD, KIND_PASSWORD, 0, 0, B_ETX, 0, 0, 64'h0, 0);
		add_row(OP_END, KIND_PASSWORD, 0, 0, 8'h00, 0, 0, 64'h0, 0);
		// Read with values off: paren still goes out, value dropped, field after it.
		add_row(OP_BEGIN, KIND_DATA_REQ, 0, 0, 8'h00, 1, 7, 64'h7F7F7F0152320200, 0);
		add_row(OP_FIELD, KIND_DATA_REQ, 0, 0, 8'h31, 0, 0, 64'h0, 0);
		add_row(OP_VALUE, KIND_DATA_REQ, 0, 0, 8'h35, 0, 0, 64'h0, 0);
		add_row(OP_FIELD, KIND_DATA_REQ, 0, 0, 8'h38, 0, 0, 64'h0, 0);
		add_row(OP_END, KIND_DATA_REQ, 0, 0, 8'h00, 0, 0, 64'h0, 0);
		// Write frame abandoned by a second begin, then values with space and ETX.
		add_row(OP_BEGIN, KIND_DATA_REQ, 1, 0, 8'h00, 1, 7, 64'h7F7F7F0157320200, 0);
		add_row(OP_FIELD, KIND_DATA_REQ, 0, 0, 8'h41, 0, 0, 64'h0, 0);
		add_row(OP_BEGIN, KIND_DATA_REQ, 0, 1, 8'h00, 0, 0, 64'h0, 0);
		add_row(OP_VALUE, KIND_DATA_REQ, 0, 0, B_SPACE, 0, 0, 64'h0, 0);
		add_row(OP_VALUE, KIND_DATA_REQ, 0, 0, B_ETX, 0, 0, 64'h0, 0);
		add_row(OP_END, KIND_DATA_REQ, 0, 0, 8'h00, 0, 0, 64'h0, 0);
		// Data request closed with no value: paren comes at the end.
		add_row(OP_BEGIN, KIND_DATA_REQ, 1, 1, 8'h00, 0, 0, 64'h0, 0);
		add_row(OP_END, KIND_DATA_REQ, 0, 0, 8'h00, 0, 0, 64'h0, 0);

		// Hold reset, then release it away from the rising edge.
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[r]) begin
			issue_request(dir_rows[r].req, !dir_rows[r].typed);
			if (dir_rows[r].typed) begin
				for (int i = 0; i < dir_rows[r].count; i++) begin
					lb.value = dir_rows[r].bytes[63 - 8 * i -: 8];
					lb.last  = dir_rows[r].ends && (i == dir_rows[r].count - 1);
					pending_bytes.push_back(lb);
				end
			end
		end

		// Random frames; run a stretch in the middle with no idling on either side.
		sent_requests = 0;
		while (sent_requests < RANDOM_TARGET) begin
			no_idle = (sent_requests >= 150 && sent_requests < 260);
			random_frame();
		end
		no_idle = 1'b0;

		@(negedge clk);
		item_ch.valid <= 1'b0;

		// Drain what is owed, then keep watching the line for stray bytes.
		drain = 0;
		while (pending_bytes.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (20) @(posedge clk);
		if (pending_bytes.size() != 0)
			report_mismatch("bytes never sent", pending_bytes.size(), 0);

		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== meter_readout_frame_builder.f =====
rtl/core/mrfb_pkg.sv
rtl/core/mrfb_item_if.sv
rtl/core/mrfb_byte_if.sv
rtl/core/mrfb_encoder.sv
rtl/core/meter_readout_frame_builder.sv
tb/sv/meter_readout_frame_builder_tb.sv
